// ===== sv/smvi_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sparse matrix-vector engine.
// Holds the word types, operation and status codes, and controller types; no dependencies.
package smvi_pkg;

    localparam int VALUE_W = 32;
    localparam int CMP_W = 18;

    typedef enum logic [2:0] {
        OP_WRITE_VECTOR = 3'd0,
        OP_APPEND       = 3'd1,
        OP_RUN          = 3'd2,
        OP_READ         = 3'd3,
        OP_CLEAR        = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic CFG_ROW_LIMIT       = 1'b0;
    localparam logic CFG_ITERATION_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]         operation;
        logic [9:0]         row_index;
        logic [9:0]         column_index;
        logic signed [31:0] operand_value;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [12:0]        stored_nonzeros;
    } result_t;

    typedef enum logic [3:0] {
        S_RST_CLR,
        S_IDLE,
        S_EXEC,
        S_RUN_CLR,
        S_PASS_CHK,
        S_NZ_ADDR,
        S_NZ_FETCH,
        S_NZ_MUL,
        S_NZ_ACC,
        S_COPY_RD,
        S_COPY_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic idx_clr;
        logic idx_inc;
        logic pass_clr;
        logic pass_inc;
        logic res_clr_wr;
        logic nz_rd;
        logic gather;
        logic mul;
        logic acc_wr;
        logic copy_rd;
        logic copy_wr;
        logic run_begin;
        logic run_end;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_run;
        logic sweep_last;
        logic copy_last;
        logic nz_last;
        logic nz_empty;
        logic pass_done;
    } sts_t;

endpackage

// ===== sv/smvi_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/smvi_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the sparse matrix-vector engine.
// Depends on smvi_pkg; drives the datapath through command and status structs.
module smvi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  smvi_pkg::sts_t  sts,
    output smvi_pkg::cmd_t  cmd
);

    smvi_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smvi_pkg::S_RST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != smvi_pkg::S_IDLE);
        case (state_reg)
            smvi_pkg::S_RST_CLR:
            begin
                cmd.res_clr_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.idx_inc = 1'b0;
                    cmd.idx_clr = 1'b1;
                    state_next = smvi_pkg::S_IDLE;
                end
            end
            smvi_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = smvi_pkg::S_EXEC;
                end
            end
            smvi_pkg::S_EXEC:
            begin
                if (sts.is_run)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.pass_clr = 1'b1;
                    cmd.run_begin = 1'b1;
                    state_next = smvi_pkg::S_RUN_CLR;
                end
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = smvi_pkg::S_FINISH;
                end
            end
            smvi_pkg::S_RUN_CLR:
            begin
                cmd.res_clr_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.idx_inc = 1'b0;
                    cmd.idx_clr = 1'b1;
                    state_next = smvi_pkg::S_PASS_CHK;
                end
            end
            smvi_pkg::S_PASS_CHK:
            begin
                if (sts.pass_done)
                begin
                    cmd.run_end = 1'b1;
                    state_next = smvi_pkg::S_FINISH;
                end
                else if (sts.nz_empty)
                begin
                    state_next = smvi_pkg::S_COPY_RD;
                end
                else
                begin
                    state_next = smvi_pkg::S_NZ_ADDR;
                end
            end
            smvi_pkg::S_NZ_ADDR:
            begin
                cmd.nz_rd = 1'b1;
                state_next = smvi_pkg::S_NZ_FETCH;
            end
            smvi_pkg::S_NZ_FETCH:
            begin
                cmd.gather = 1'b1;
                state_next = smvi_pkg::S_NZ_MUL;
            end
            smvi_pkg::S_NZ_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = smvi_pkg::S_NZ_ACC;
            end
            smvi_pkg::S_NZ_ACC:
            begin
                cmd.acc_wr = 1'b1;
                if (sts.nz_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next = smvi_pkg::S_COPY_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = smvi_pkg::S_NZ_ADDR;
                end
            end
            smvi_pkg::S_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next = smvi_pkg::S_COPY_WR;
            end
            smvi_pkg::S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (sts.copy_last)
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.pass_inc = 1'b1;
                    state_next = smvi_pkg::S_PASS_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = smvi_pkg::S_COPY_RD;
                end
            end
            smvi_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = smvi_pkg::S_IDLE;
            end
            default:
            begin
                state_next = smvi_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/smvi_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the sparse matrix-vector engine: stores, counters, multiplier, accumulator.
// Depends on smvi_pkg and smvi_ram.
module smvi_dp #(
    parameter int ROW_MAX = 1024,
    parameter int NONZERO_MAX = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  smvi_pkg::item_t   item,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [10:0]       cfg_data,
    input  smvi_pkg::cmd_t    cmd,
    output smvi_pkg::sts_t    sts,
    output logic              done,
    output smvi_pkg::result_t result
);

    localparam int RA_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int NA_W = (NONZERO_MAX > 1) ? $clog2(NONZERO_MAX) : 1;
    localparam int FILL_W = $clog2(NONZERO_MAX + 1);
    localparam int IDX_W = ((RA_W > NA_W) ? RA_W : NA_W) + 1;
    localparam int NZ_W = 2 * RA_W + smvi_pkg::VALUE_W;
    localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VMIN = 32'sh8000_0000;

    logic [10:0]           row_limit_reg;
    logic [7:0]            iter_count_reg;
    smvi_pkg::item_t       item_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [7:0]            pass_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic                  sat_seen_reg;
    logic                  run_sat_reg;
    logic [1:0]            code_reg;
    logic signed [63:0]    prod_reg;
    logic signed [31:0]    acc_reg;
    logic [RA_W-1:0]       row_reg;
    logic                  stale_reg;
    logic                  done_reg;
    smvi_pkg::result_t     result_reg;

    logic [smvi_pkg::CMP_W-1:0] rc_ext, rows;
    logic                  row_bad, col_bad, full;
    logic                  do_vec_wr, do_append, do_read;
    logic [NZ_W-1:0]       nz_wdata, nz_rdata;
    logic [RA_W-1:0]       nz_row, nz_col;
    logic signed [31:0]    nz_val;
    logic [31:0]           vec_rdata, res_rdata;
    logic                  vec_we, res_we;
    logic [RA_W-1:0]       vec_waddr, res_waddr, res_raddr, item_row;
    logic [31:0]           vec_wdata, res_wdata;
    logic                  res_re;
    logic signed [63:0]    shifted;
    logic signed [31:0]    term, sum;
    logic                  term_sat, sum_sat;
    logic signed [32:0]    wide_sum;
    logic [63:0]           fill_ext;

    assign rc_ext = smvi_pkg::CMP_W'(row_limit_reg);
    always_comb
    begin
        if (rc_ext == '0)
        begin
            rows = smvi_pkg::CMP_W'(1);
        end
        else if (rc_ext > smvi_pkg::CMP_W'(ROW_MAX))
        begin
            rows = smvi_pkg::CMP_W'(ROW_MAX);
        end
        else
        begin
            rows = rc_ext;
        end
    end

    assign row_bad = smvi_pkg::CMP_W'(item_reg.row_index) >= rows;
    assign col_bad = smvi_pkg::CMP_W'(item_reg.column_index) >= rows;
    assign full = (32'(fill_reg) == 32'(NONZERO_MAX));
    assign item_row = RA_W'(item_reg.row_index);

    assign do_vec_wr = cmd.exec && (item_reg.operation == smvi_pkg::OP_WRITE_VECTOR) && !row_bad;
    assign do_append = cmd.exec && (item_reg.operation == smvi_pkg::OP_APPEND)
                       && !row_bad && !col_bad && !full;
    assign do_read = cmd.exec && (item_reg.operation == smvi_pkg::OP_READ) && !row_bad;

    assign sts.is_run = (item_reg.operation == smvi_pkg::OP_RUN);
    assign sts.sweep_last = (32'(idx_reg) == 32'(ROW_MAX - 1));
    assign sts.copy_last = (smvi_pkg::CMP_W'(idx_reg) == rows - smvi_pkg::CMP_W'(1));
    assign sts.nz_last = (32'(idx_reg) + 32'd1 >= 32'(fill_reg));
    assign sts.nz_empty = (fill_reg == '0);
    assign sts.pass_done = (pass_reg == iter_count_reg);

    assign nz_wdata = {RA_W'(item_reg.row_index), RA_W'(item_reg.column_index),
                       item_reg.operand_value};
    assign nz_row = nz_rdata[NZ_W-1 -: RA_W];
    assign nz_col = nz_rdata[NZ_W-RA_W-1 -: RA_W];
    assign nz_val = nz_rdata[31:0];

    smvi_ram #(.WIDTH(NZ_W), .DEPTH(NONZERO_MAX)) u_nz_ram (
        .clk   (clk),
        .we    (do_append),
        .waddr (NA_W'(fill_reg)),
        .wdata (nz_wdata),
        .re    (cmd.nz_rd),
        .raddr (NA_W'(idx_reg)),
        .rdata (nz_rdata)
    );

    assign vec_we = do_vec_wr || cmd.copy_wr;
    assign vec_waddr = cmd.copy_wr ? RA_W'(idx_reg) : item_row;
    assign vec_wdata = cmd.copy_wr ? res_rdata : item_reg.operand_value;

    smvi_ram #(.WIDTH(32), .DEPTH(ROW_MAX)) u_vec_ram (
        .clk   (clk),
        .we    (vec_we),
        .waddr (vec_waddr),
        .wdata (vec_wdata),
        .re    (cmd.gather),
        .raddr (nz_col),
        .rdata (vec_rdata)
    );

    assign res_we = cmd.res_clr_wr || (cmd.acc_wr && !stale_reg);
    assign res_waddr = cmd.res_clr_wr ? RA_W'(idx_reg) : row_reg;
    assign res_wdata = cmd.res_clr_wr ? 32'd0 : sum;
    assign res_re = cmd.gather || cmd.copy_rd || do_read;
    assign res_raddr = cmd.gather ? nz_row : (cmd.copy_rd ? RA_W'(idx_reg) : item_row);

    smvi_ram #(.WIDTH(32), .DEPTH(ROW_MAX)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (res_re),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // The product is in Q.32; an arithmetic shift gives the floor of the Q.16 value.
    assign shifted = prod_reg >>> 16;
    always_comb
    begin
        term_sat = 1'b0;
        term = shifted[31:0];
        if (shifted > 64'(VMAX))
        begin
            term = VMAX;
            term_sat = 1'b1;
        end
        else if (shifted < 64'(VMIN))
        begin
            term = VMIN;
            term_sat = 1'b1;
        end
        wide_sum = 33'(acc_reg) + 33'(term);
        sum_sat = 1'b0;
        sum = wide_sum[31:0];
        if (wide_sum > 33'(VMAX))
        begin
            sum = VMAX;
            sum_sat = 1'b1;
        end
        else if (wide_sum < 33'(VMIN))
        begin
            sum = VMIN;
            sum_sat = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.mul)
        begin
            prod_reg <= 64'(nz_val) * 64'($signed(vec_rdata));
            acc_reg <= res_rdata;
            row_reg <= nz_row;
            stale_reg <= (smvi_pkg::CMP_W'(nz_row) >= rows) || (smvi_pkg::CMP_W'(nz_col) >= rows);
        end
        if (cmd.exec)
        begin
            if (item_reg.operation == smvi_pkg::OP_WRITE_VECTOR)
            begin
                code_reg <= row_bad ? smvi_pkg::ST_RANGE : smvi_pkg::ST_OK;
            end
            else if (item_reg.operation == smvi_pkg::OP_APPEND)
            begin
                code_reg <= (row_bad || col_bad) ? smvi_pkg::ST_RANGE :
                            (full ? smvi_pkg::ST_FULL : smvi_pkg::ST_OK);
            end
            else
            begin
                code_reg <= smvi_pkg::ST_OK;
            end
        end
    end

    assign fill_ext = 64'(fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_limit_reg <= 11'd1024;
            iter_count_reg <= 8'd1;
            idx_reg <= '0;
            pass_reg <= '0;
            fill_reg <= '0;
            sat_seen_reg <= 1'b0;
            run_sat_reg <= 1'b0;
            done_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == smvi_pkg::CFG_ROW_LIMIT)
                begin
                    row_limit_reg <= cfg_data;
                end
                else
                begin
                    iter_count_reg <= cfg_data[7:0];
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.pass_clr)
            begin
                pass_reg <= '0;
            end
            else if (cmd.pass_inc)
            begin
                pass_reg <= pass_reg + 8'd1;
            end
            if (do_append)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (cmd.exec && item_reg.operation == smvi_pkg::OP_CLEAR)
            begin
                fill_reg <= '0;
            end
            if (cmd.run_begin)
            begin
                run_sat_reg <= 1'b0;
            end
            else if (cmd.acc_wr && !stale_reg && (term_sat || sum_sat))
            begin
                run_sat_reg <= 1'b1;
            end
            if (cmd.run_end)
            begin
                sat_seen_reg <= run_sat_reg;
            end
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                result_reg.stored_nonzeros <= fill_ext[12:0];
                if (item_reg.operation == smvi_pkg::OP_RUN)
                begin
                    result_reg.status <= run_sat_reg ? smvi_pkg::ST_SAT : smvi_pkg::ST_OK;
                    result_reg.read_value <= '0;
                end
                else if ((item_reg.operation == smvi_pkg::OP_READ) && !row_bad)
                begin
                    result_reg.status <= sat_seen_reg ? smvi_pkg::ST_SAT : smvi_pkg::ST_OK;
                    result_reg.read_value <= res_rdata;
                end
                else if (item_reg.operation == smvi_pkg::OP_READ)
                begin
                    result_reg.status <= smvi_pkg::ST_RANGE;
                    result_reg.read_value <= '0;
                end
                else
                begin
                    result_reg.status <= code_reg;
                    result_reg.read_value <= '0;
                end
            end
        end
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/sparse_matrix_vector_iterate.sv =====
`timescale 1ns / 1ps
// Coordinate-format sparse matrix-vector engine, top level; depends on smvi_pkg,
// smvi_ctrl and smvi_dp. A write, append, read or clear goes from the accepting edge
// through EXEC and FINISH to a registered done strobe; no new word is taken until the
// block is idle again. A run's pace is set by the result memory, whose one read and one
// write port serve clearing, accumulation and copy. After reset the block is busy while
// it clears the result store; done cannot be stalled.
module sparse_matrix_vector_iterate #(
    parameter int ROW_MAX = 1024,
    parameter int NONZERO_MAX = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  smvi_pkg::item_t   item,
    output logic              done,
    output smvi_pkg::result_t result,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [10:0]       cfg_data
);

    smvi_pkg::cmd_t cmd;
    smvi_pkg::sts_t sts;

    smvi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    smvi_dp #(
        .ROW_MAX     (ROW_MAX),
        .NONZERO_MAX (NONZERO_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .result    (result)
    );

endmodule
